// File: rtl/udp_receive_port_filter_core_defines.svh
// Assertion macros for the UDP receive port filter.
`ifndef UDP_RECEIVE_PORT_FILTER_CORE_DEFINES_SVH
`define UDP_RECEIVE_PORT_FILTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication: whenever a holds, c holds too.
`define UDPRF_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("udprf assertion failed");
// Next-cycle implication: whenever a holds, c holds in the following cycle.
`define UDPRF_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("udprf assertion failed");
`else
`define UDPRF_ASSERT_IMPL(label, clk, rst_n, a, c)
`define UDPRF_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif

`endif

// File: rtl/udprf_pkg.sv
package udprf_pkg;

    // Table size and the widths that follow from it
    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int SLOT_W        = 4;

    // APB-style register port
    localparam int ADDR_W        = 3;
    localparam int DATA_W        = 32;
    localparam logic REG_OWN_IP  = 1'b0;

    localparam logic       CMD_REGISTER = 1'b0;
    localparam logic       CMD_CLASSIFY = 1'b1;
    localparam logic [7:0] PROTO_UDP    = 8'd17;
    localparam logic [15:0] UDP_HDR_LEN = 16'd8;

    typedef enum logic [2:0] {
        ST_REGISTERED = 3'd0,
        ST_FULL       = 3'd1,
        ST_DELIVERED  = 3'd2,
        ST_DROPPED    = 3'd3,
        ST_LEN_ERROR  = 3'd4
    } status_t;

    typedef struct packed {
        logic        command;
        logic [7:0]  ip_protocol;
        logic [31:0] src_ip;
        logic [31:0] dest_ip;
        logic [15:0] dst_port;
        logic [15:0] udp_length;
        logic [7:0]  handler_tag;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic [SLOT_W-1:0] slot;
        logic [7:0]        matched_tag;
        logic [15:0]       payload_length;
    } res_t;

    // Lookup token handed from cell to cell
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] count;
        logic [31:0]      ip;
        logic [15:0]      port;
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic [7:0]       tag;
    } probe_t;

    // Entry write bundle
    typedef struct packed {
        logic        en;
        logic [31:0] ip;
        logic [15:0] port;
        logic [7:0]  tag;
    } entry_wr_t;

endpackage

// File: rtl/udp_receive_port_filter_core.sv
// UDP receive port filter. A request either registers a filter entry
// (destination IP, port, handler tag) in the next free slot, or classifies
// the header of a received frame. Frames that are not UDP or that come from
// own_ip (register at byte address 0) are dropped at once; otherwise a lookup
// token walks a row of TABLE_ENTRIES cells, one cell per clock, and the lowest
// live entry with equal IP and port claims it. Register requests and early
// drops go from acceptance through the pending register to the output
// register; a table lookup first passes every cell register of the row.
// One request is in flight at a time, but a finished result sits in
// the output register so the next request can be taken while it waits.
// There is no clearing pass; unwritten entries are never consulted.
`include "udp_receive_port_filter_core_defines.svh"

module udp_receive_port_filter_core (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          req_valid,
    output logic                          req_ready,
    input  udprf_pkg::req_t               req_data,
    // result channel
    output logic                          res_valid,
    input  logic                          res_ready,
    output udprf_pkg::res_t               res_data,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [udprf_pkg::ADDR_W-1:0]  paddr,
    input  logic [udprf_pkg::DATA_W-1:0]  pwdata,
    output logic [udprf_pkg::DATA_W-1:0]  prdata,
    output logic                          pready
);

    localparam int N     = udprf_pkg::TABLE_ENTRIES;
    localparam int CNT_W = udprf_pkg::CNT_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,   // ready for a request
        S_BUSY = 3'b010,   // token travelling down the cell row
        S_HOLD = 3'b100    // result ready, waiting for the output register
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [31:0]           own_ip_reg, own_ip_next;
    logic [15:0]           ulen_reg, ulen_next;
    udprf_pkg::res_t       pend_reg, pend_next;
    udprf_pkg::res_t       res_reg, res_next;
    logic                  res_valid_reg, res_valid_next;

    logic                  accept;
    logic                  cfg_wr;
    logic                  is_register;
    logic                  table_full;
    logic                  frame_ok;
    logic                  inject_valid;
    udprf_pkg::probe_t     inject;
    udprf_pkg::res_t       lookup_res;

    logic                  probe_valid_w [0:N];
    udprf_pkg::probe_t     probe_w       [0:N];

    // ---------------------------------------------------------------
    // Register port: own_ip only, no wait states
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                 && (paddr[udprf_pkg::ADDR_W-1:2] == udprf_pkg::REG_OWN_IP);

    always_comb
    begin
        if (paddr[udprf_pkg::ADDR_W-1:2] == udprf_pkg::REG_OWN_IP)
            prdata = own_ip_reg;
        else
            prdata = '0;
    end

    assign own_ip_next = cfg_wr ? pwdata : own_ip_reg;

    // ---------------------------------------------------------------
    // Request decode
    // ---------------------------------------------------------------
    assign req_ready    = (state_reg == S_IDLE);
    assign accept       = req_valid && req_ready;
    assign is_register  = (req_data.command == udprf_pkg::CMD_REGISTER);
    assign table_full   = (count_reg >= CNT_W'(N));
    assign frame_ok     = (req_data.ip_protocol == udprf_pkg::PROTO_UDP)
                       && (req_data.src_ip != own_ip_reg);
    assign inject_valid = accept && !is_register && frame_ok;

    always_comb
    begin
        inject         = '0;
        inject.count   = count_reg;
        inject.ip      = req_data.dest_ip;
        inject.port    = req_data.dst_port;
    end

    assign probe_valid_w[0] = inject_valid;
    assign probe_w[0]       = inject;

    // ---------------------------------------------------------------
    // Cell row: one entry per cell, the token shifts one cell a clock
    // ---------------------------------------------------------------
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        udprf_pkg::entry_wr_t wr;

        always_comb
        begin
            wr.en   = accept && is_register && !table_full
                   && (count_reg == CNT_W'(i));
            wr.ip   = req_data.dest_ip;
            wr.port = req_data.dst_port;
            wr.tag  = req_data.handler_tag;
        end

        udprf_cell u_cell (
            .clk             (clk),
            .rst_n           (rst_n),
            .wr              (wr),
            .probe_in_valid  (probe_valid_w[i]),
            .probe_in        (probe_w[i]),
            .probe_out_valid (probe_valid_w[i+1]),
            .probe_out       (probe_w[i+1])
        );
    end

    // Turn the token leaving the last cell into a result
    always_comb
    begin
        lookup_res = '0;
        lookup_res.status = udprf_pkg::ST_DROPPED;
        if (probe_w[N].hit)
        begin
            lookup_res.slot        = udprf_pkg::SLOT_W'(probe_w[N].hit_idx);
            lookup_res.matched_tag = probe_w[N].tag;
            if (ulen_reg < udprf_pkg::UDP_HDR_LEN)
            begin
                lookup_res.status = udprf_pkg::ST_LEN_ERROR;
            end
            else
            begin
                lookup_res.status         = udprf_pkg::ST_DELIVERED;
                lookup_res.payload_length = ulen_reg - udprf_pkg::UDP_HDR_LEN;
            end
        end
    end

    // ---------------------------------------------------------------
    // Control
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ulen_next      = ulen_reg;
        pend_next      = pend_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;

        if (res_valid_reg && res_ready)
            res_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pend_next = '0;
                    if (is_register)
                    begin
                        if (table_full)
                        begin
                            pend_next.status = udprf_pkg::ST_FULL;
                        end
                        else
                        begin
                            pend_next.status = udprf_pkg::ST_REGISTERED;
                            pend_next.slot   = udprf_pkg::SLOT_W'(count_reg);
                            count_next       = count_reg + CNT_W'(1);
                        end
                        state_next = S_HOLD;
                    end
                    else if (!frame_ok)
                    begin
                        pend_next.status = udprf_pkg::ST_DROPPED;
                        state_next       = S_HOLD;
                    end
                    else
                    begin
                        ulen_next  = req_data.udp_length;
                        state_next = S_BUSY;
                    end
                end
            end
            S_BUSY:
            begin
                if (probe_valid_w[N])
                begin
                    pend_next  = lookup_res;
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_next       = pend_reg;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            own_ip_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            own_ip_reg    <= own_ip_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ulen_reg <= ulen_next;
        pend_reg <= pend_next;
        res_reg  <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // The fill count never passes the table size
    `UDPRF_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(N))
    // A token only leaves the row while a lookup is outstanding
    `UDPRF_ASSERT_IMPL(a_token_busy, clk, rst_n, probe_valid_w[N], state_reg == S_BUSY)
    // A register request with room advances the fill count by one
    `UDPRF_ASSERT_NEXT(a_count_step, clk, rst_n, accept && is_register && !table_full,
        count_reg == $past(count_reg) + CNT_W'(1))

endmodule

// File: rtl/udprf_cell.sv
module udprf_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  udprf_pkg::entry_wr_t wr,
    input  logic                probe_in_valid,
    input  udprf_pkg::probe_t   probe_in,
    output logic                probe_out_valid,
    output udprf_pkg::probe_t   probe_out
);

    logic [31:0]       entry_ip_reg;
    logic [15:0]       entry_port_reg;
    logic [7:0]        entry_tag_reg;
    logic              valid_reg;
    logic              valid_next;
    udprf_pkg::probe_t probe_reg;
    udprf_pkg::probe_t probe_next;
    logic              match;

    // Only the first live entry that matches claims the token
    assign match = !probe_in.hit
                 && (udprf_pkg::CNT_W'(probe_in.idx) < probe_in.count)
                 && (probe_in.ip == entry_ip_reg)
                 && (probe_in.port == entry_port_reg);

    always_comb
    begin
        valid_next         = probe_in_valid;
        probe_next         = probe_in;
        probe_next.idx     = probe_in.idx + udprf_pkg::IDX_W'(1);
        if (match)
        begin
            probe_next.hit     = 1'b1;
            probe_next.hit_idx = probe_in.idx;
            probe_next.tag     = entry_tag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        probe_reg <= probe_next;
        if (wr.en)
        begin
            entry_ip_reg   <= wr.ip;
            entry_port_reg <= wr.port;
            entry_tag_reg  <= wr.tag;
        end
    end

    assign probe_out_valid = valid_reg;
    assign probe_out       = probe_reg;

endmodule

// File: verif/tb_udp_receive_port_filter_core.sv
`timescale 1ns / 1ps

// Testbench for the UDP receive port filter.
// A short directed script fills the filter table, overflows it and walks the
// classify corner cases (header length extremes, not-UDP, own source, no
// match, first-match priority). Four random phases follow, each under its
// own own_ip setting and flow-control mix. Every accepted request is run
// through a local model of the filter. The hand-written outcome of a directed
// row, or else the model's, is queued and compared field by field with the next result the block hands out.
module tb_udp_receive_port_filter_core;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_ITEMS = 225;      // per phase, four phases
    localparam int PHASES       = 4;

    // own_ip is register 0; the next word is past the end of the register list
    localparam logic [udprf_pkg::ADDR_W-1:0] OWN_IP_ADDR =
        udprf_pkg::ADDR_W'(4 * udprf_pkg::REG_OWN_IP);
    localparam logic [udprf_pkg::ADDR_W-1:0] SPARE_ADDR  = udprf_pkg::ADDR_W'(4);

    typedef struct packed {
        udprf_pkg::req_t rq;
        logic            typed;     // 1: want holds the hand-written outcome
        udprf_pkg::res_t want;
    } script_row_t;

    // ------------------------------------------------------------------
    // DUT inputs, all known from time zero
    // ------------------------------------------------------------------
    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         req_valid = 1'b0;
    logic                         req_ready;
    udprf_pkg::req_t              req_data  = '0;
    logic                         res_valid;
    logic                         res_ready = 1'b0;
    udprf_pkg::res_t              res_data;
    logic                         psel      = 1'b0;
    logic                         penable   = 1'b0;
    logic                         pwrite    = 1'b0;
    logic [udprf_pkg::ADDR_W-1:0] paddr     = '0;
    logic [udprf_pkg::DATA_W-1:0] pwdata    = '0;
    logic [udprf_pkg::DATA_W-1:0] prdata;
    logic                         pready;

    // ------------------------------------------------------------------
    // Filter model state and scoreboard
    // ------------------------------------------------------------------
    logic [31:0] filt_ip   [udprf_pkg::TABLE_ENTRIES];
    logic [15:0] filt_port [udprf_pkg::TABLE_ENTRIES];
    logic [7:0]  filt_tag  [udprf_pkg::TABLE_ENTRIES];
    int          filt_count  = 0;
    logic [31:0] own_ip_cfg  = '0;

    udprf_pkg::res_t pending_outcomes [$];
    script_row_t     directed_script  [$];

    // hand-written outcome travelling alongside the request on offer
    logic            row_typed = 1'b0;
    udprf_pkg::res_t row_want  = '0;

    int          tx_idle_pct  = 0;
    int          rx_stall_pct = 0;
    int          rx_hold_left = 0;     // long receiver hold-off, in cycles
    int          err_count    = 0;
    int          cycle_count  = 0;
    int          req_count    = 0;
    int          outcome_tally [5];

    udp_receive_port_filter_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Watchdog: a hang anywhere ends the run here
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // Outcome of one request; a register request also updates the table copy.
    // Lookups take the lowest-numbered entry with equal IP and port.
    function automatic udprf_pkg::res_t udp_filter_outcome(input udprf_pkg::req_t rq);
        udprf_pkg::res_t o;
        bit              hit;
        o        = '0;
        o.status = udprf_pkg::ST_DROPPED;
        hit      = 1'b0;
        if (rq.command == udprf_pkg::CMD_REGISTER)
        begin
            if (filt_count >= udprf_pkg::TABLE_ENTRIES)
            begin
                o.status = udprf_pkg::ST_FULL;
            end
            else
            begin
                filt_ip[filt_count]   = rq.dest_ip;
                filt_port[filt_count] = rq.dst_port;
                filt_tag[filt_count]  = rq.handler_tag;
                o.status              = udprf_pkg::ST_REGISTERED;
                o.slot                = udprf_pkg::SLOT_W'(filt_count);
                filt_count++;
            end
        end
        else if (rq.ip_protocol == udprf_pkg::PROTO_UDP && rq.src_ip != own_ip_cfg)
        begin
            for (int i = 0; i < filt_count; i++)
            begin
                if (!hit && filt_ip[i] == rq.dest_ip && filt_port[i] == rq.dst_port)
                begin
                    hit           = 1'b1;
                    o.slot        = udprf_pkg::SLOT_W'(i);
                    o.matched_tag = filt_tag[i];
                    if (rq.udp_length < udprf_pkg::UDP_HDR_LEN)
                    begin
                        o.status = udprf_pkg::ST_LEN_ERROR;
                    end
                    else
                    begin
                        o.status         = udprf_pkg::ST_DELIVERED;
                        o.payload_length = rq.udp_length - udprf_pkg::UDP_HDR_LEN;
                    end
                end
            end
        end
        return o;
    endfunction

    // Unused fields of a register request are filled with noise
    task automatic add_register_row(input logic [31:0] ip, input logic [15:0] port,
                                    input logic [7:0] tag, input udprf_pkg::status_t st,
                                    input int slot);
        script_row_t r;
        r.rq.command     = udprf_pkg::CMD_REGISTER;
        r.rq.ip_protocol = 8'($urandom);
        r.rq.src_ip      = $urandom;
        r.rq.dest_ip     = ip;
        r.rq.dst_port    = port;
        r.rq.udp_length  = 16'($urandom);
        r.rq.handler_tag = tag;
        r.typed          = 1'b1;
        r.want           = '0;
        r.want.status    = st;
        r.want.slot      = udprf_pkg::SLOT_W'(slot);
        directed_script.push_back(r);
    endtask

    task automatic add_classify_row(input logic [7:0] proto, input logic [31:0] src,
                                    input logic [31:0] ip, input logic [15:0] port,
                                    input logic [15:0] len, input logic typed,
                                    input udprf_pkg::status_t st, input int slot,
                                    input logic [7:0] tag, input logic [15:0] plen);
        script_row_t r;
        r.rq.command          = udprf_pkg::CMD_CLASSIFY;
        r.rq.ip_protocol      = proto;
        r.rq.src_ip           = src;
        r.rq.dest_ip          = ip;
        r.rq.dst_port         = port;
        r.rq.udp_length       = len;
        r.rq.handler_tag      = 8'($urandom);
        r.typed               = typed;
        r.want.status         = st;
        r.want.slot           = udprf_pkg::SLOT_W'(slot);
        r.want.matched_tag    = tag;
        r.want.payload_length = plen;
        directed_script.push_back(r);
    endtask

    // Mostly well-formed UDP headers aimed at live entries, with near misses,
    // short lengths, foreign protocols, own-source frames and register noise
    function automatic udprf_pkg::req_t random_request();
        udprf_pkg::req_t rq;
        int              k;
        int              b;
        int              r;
        rq.command     = udprf_pkg::CMD_CLASSIFY;
        rq.ip_protocol = 8'($urandom);
        rq.src_ip      = $urandom;
        rq.dest_ip     = $urandom;
        rq.dst_port    = 16'($urandom);
        rq.udp_length  = 16'($urandom);
        rq.handler_tag = 8'($urandom);
        if ($urandom_range(99) < 10)
        begin
            rq.command = udprf_pkg::CMD_REGISTER;
        end
        else
        begin
            if ($urandom_range(99) < 85)
            begin
                rq.ip_protocol = udprf_pkg::PROTO_UDP;
            end
            if ($urandom_range(99) < 12)
            begin
                rq.src_ip = own_ip_cfg;
            end
            if (filt_count > 0 && $urandom_range(99) < 70)
            begin
                k           = $urandom_range(filt_count - 1);
                rq.dest_ip  = filt_ip[k];
                rq.dst_port = filt_port[k];
                if ($urandom_range(99) < 15)
                begin
                    if ($urandom_range(1) == 1)
                    begin
                        b             = $urandom_range(31);
                        rq.dest_ip[b] = ~rq.dest_ip[b];
                    end
                    else
                    begin
                        b              = $urandom_range(15);
                        rq.dst_port[b] = ~rq.dst_port[b];
                    end
                end
            end
            r = $urandom_range(99);
            if (r < 15)
            begin
                rq.udp_length = 16'($urandom_range(8));
            end
            else if (r < 20)
            begin
                rq.udp_length = 16'hffff;
            end
        end
        return rq;
    endfunction

    // ------------------------------------------------------------------
    // Request side: drive on the falling edge, return at acceptance
    // ------------------------------------------------------------------
    task automatic offer_request(input udprf_pkg::req_t rq, input logic typed,
                                 input udprf_pkg::res_t want);
        @(negedge clk);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            req_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
        req_valid <= 1'b1;
        req_data  <= rq;
        row_typed <= typed;
        row_want  <= want;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    // Stop offering and wait for every queued outcome to come back
    task automatic drain_results();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // One APB transfer: setup cycle, then access until pready
    task automatic apb_xfer(input logic wr, input logic [udprf_pkg::ADDR_W-1:0] addr,
                            input logic [udprf_pkg::DATA_W-1:0] wdata,
                            output logic [udprf_pkg::DATA_W-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_own_ip();
        logic [udprf_pkg::DATA_W-1:0] rd;
        apb_xfer(1'b0, OWN_IP_ADDR, '0, rd);
        if (rd !== own_ip_cfg)
        begin
            report_mismatch($sformatf("own_ip readback %08h, want %08h", rd, own_ip_cfg));
        end
    endtask

    // Only called with the block idle; a write past the list changes nothing
    task automatic program_reg(input logic [udprf_pkg::ADDR_W-1:0] addr,
                               input logic [udprf_pkg::DATA_W-1:0] value);
        logic [udprf_pkg::DATA_W-1:0] unused;
        apb_xfer(1'b1, addr, value, unused);
        if (addr == OWN_IP_ADDR)
        begin
            own_ip_cfg = value;
        end
        check_own_ip();
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls plus an occasional long hold-off
    // ------------------------------------------------------------------
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rx_hold_left > 0)
            begin
                res_ready <= 1'b0;
                rx_hold_left--;
            end
            else
            begin
                res_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Scoreboard: predict at request acceptance, check at result acceptance
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : outcome_check
        udprf_pkg::res_t got;
        udprf_pkg::res_t want;
        udprf_pkg::res_t predicted;
        if (rst_n)
        begin
            if (res_valid && res_ready)
            begin
                got = res_data;
                if (pending_outcomes.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d/%0d/%02h/%0d with nothing pending",
                                              got.status, got.slot, got.matched_tag,
                                              got.payload_length));
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    outcome_tally[want.status]++;
                    if (got.status !== want.status)
                    begin
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  got.status, want.status));
                    end
                    if (got.slot !== want.slot)
                    begin
                        report_mismatch($sformatf("slot %0d, want %0d", got.slot, want.slot));
                    end
                    if (got.matched_tag !== want.matched_tag)
                    begin
                        report_mismatch($sformatf("matched_tag %02h, want %02h",
                                                  got.matched_tag, want.matched_tag));
                    end
                    if (got.payload_length !== want.payload_length)
                    begin
                        report_mismatch($sformatf("payload_length %0d, want %0d",
                                                  got.payload_length, want.payload_length));
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                // model always runs so the table copy follows register requests
                predicted = udp_filter_outcome(req_data);
                pending_outcomes.push_back(row_typed ? row_want : predicted);
                req_count++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int          phase_idle  [PHASES];
        int          phase_stall [PHASES];
        logic [31:0] phase_ip    [PHASES];

        // Fill the table: extremes, a first-match group sharing one IP and port,
        // neighbours differing in port or IP only
        add_register_row(32'h00000000, 16'h0000, 8'h00, udprf_pkg::ST_REGISTERED, 0);
        add_register_row(32'hffffffff, 16'hffff, 8'hff, udprf_pkg::ST_REGISTERED, 1);
        add_register_row(32'hc0a80001, 16'h0035, 8'h11, udprf_pkg::ST_REGISTERED, 2);
        add_register_row(32'hc0a80001, 16'h0035, 8'h22, udprf_pkg::ST_REGISTERED, 3);
        add_register_row(32'hc0a80001, 16'h0036, 8'h33, udprf_pkg::ST_REGISTERED, 4);
        add_register_row(32'hc0a80002, 16'h0035, 8'h44, udprf_pkg::ST_REGISTERED, 5);
        add_register_row(32'h0a000001, 16'h1f90, 8'h55, udprf_pkg::ST_REGISTERED, 6);
        add_register_row(32'h0a000001, 16'h0000, 8'h66, udprf_pkg::ST_REGISTERED, 7);
        add_register_row(32'h00000000, 16'hffff, 8'h77, udprf_pkg::ST_REGISTERED, 8);
        add_register_row(32'hffffffff, 16'h0000, 8'h88, udprf_pkg::ST_REGISTERED, 9);
        add_register_row(32'h7f000001, 16'h0bb8, 8'h99, udprf_pkg::ST_REGISTERED, 10);
        add_register_row(32'hac100001, 16'hc350, 8'haa, udprf_pkg::ST_REGISTERED, 11);
        add_register_row(32'h80000000, 16'h8000, 8'hbb, udprf_pkg::ST_REGISTERED, 12);
        add_register_row(32'h55555555, 16'haaaa, 8'hcc, udprf_pkg::ST_REGISTERED, 13);
        add_register_row(32'haaaaaaaa, 16'h5555, 8'hdd, udprf_pkg::ST_REGISTERED, 14);
        add_register_row(32'hc0a80001, 16'h0035, 8'hee, udprf_pkg::ST_REGISTERED, 15);
        // table full: nothing stored, all other fields zero
        add_register_row(32'h12345678, 16'h4321, 8'h5a, udprf_pkg::ST_FULL, 0);
        // largest and smallest deliverable lengths
        add_classify_row(udprf_pkg::PROTO_UDP, 32'h01020304, 32'hffffffff, 16'hffff, 16'hffff,
                         1'b1, udprf_pkg::ST_DELIVERED, 1, 8'hff, 16'hfff7);
        add_classify_row(udprf_pkg::PROTO_UDP, 32'h01020304, 32'h00000000, 16'h0000, 16'h0008,
                         1'b1, udprf_pkg::ST_DELIVERED, 0, 8'h00, 16'h0000);
        // short UDP length keeps slot and tag
        add_classify_row(udprf_pkg::PROTO_UDP, 32'h01020304, 32'hffffffff, 16'hffff, 16'h0007,
                         1'b1, udprf_pkg::ST_LEN_ERROR, 1, 8'hff, 16'h0000);
        add_classify_row(udprf_pkg::PROTO_UDP, 32'h01020304, 32'h00000000, 16'h0000, 16'h0000,
                         1'b1, udprf_pkg::ST_LEN_ERROR, 0, 8'h00, 16'h0000);
        // first-match group: model decides
        add_classify_row(udprf_pkg::PROTO_UDP, 32'h01020304, 32'hc0a80001, 16'h0035, 16'h0040,
                         1'b0, udprf_pkg::ST_DROPPED, 0, 8'h00, 16'h0000);
        // no entry with this port
        add_classify_row(udprf_pkg::PROTO_UDP, 32'h01020304, 32'hc0a80001, 16'h0037, 16'h0040,
                         1'b1, udprf_pkg::ST_DROPPED, 0, 8'h00, 16'h0000);
        // TCP frame to a live entry
        add_classify_row(8'd6, 32'h01020304, 32'h00000000, 16'h0000, 16'h0040,
                         1'b1, udprf_pkg::ST_DROPPED, 0, 8'h00, 16'h0000);
        // own source (own_ip still at reset value 0)
        add_classify_row(udprf_pkg::PROTO_UDP, 32'h00000000, 32'h00000000, 16'h0000, 16'h0040,
                         1'b1, udprf_pkg::ST_DROPPED, 0, 8'h00, 16'h0000);

        // Phase plan: free flow, sender gaps, receiver stalls, both
        phase_idle  = '{0, 52, 0, 21};
        phase_stall = '{0, 0, 52, 21};
        phase_ip    = '{32'hffffffff, $urandom, 32'hc0a80002, 32'h00000000};

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        check_own_ip();
        foreach (directed_script[n])
        begin
            offer_request(directed_script[n].rq, directed_script[n].typed,
                          directed_script[n].want);
        end
        drain_results();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph == 1)
            begin
                program_reg(SPARE_ADDR, $urandom);
            end
            program_reg(OWN_IP_ADDR, phase_ip[ph]);
            tx_idle_pct  = phase_idle[ph];
            rx_stall_pct = phase_stall[ph];
            for (int n = 0; n < RANDOM_ITEMS; n++)
            begin
                offer_request(random_request(), 1'b0, '0);
                // back-pressure: result side holds off while requests keep coming
                if (ph == 0 && n == 60)
                begin
                    rx_hold_left = 300;
                end
                // sender waits for the block to empty completely
                if (ph == 1 && n == 100)
                begin
                    drain_results();
                end
            end
            drain_results();
        end

        // tail: room for a stray result after the last lookup
        repeat (udprf_pkg::TABLE_ENTRIES + 8) @(posedge clk);

        $display("%0d requests over directed script and %0d flow-control phases, %0d cycles",
                 req_count, PHASES, cycle_count);
        $display("outcomes: %0d registered, %0d full, %0d delivered, %0d dropped, %0d len err",
                 outcome_tally[udprf_pkg::ST_REGISTERED], outcome_tally[udprf_pkg::ST_FULL],
                 outcome_tally[udprf_pkg::ST_DELIVERED], outcome_tally[udprf_pkg::ST_DROPPED],
                 outcome_tally[udprf_pkg::ST_LEN_ERROR]);
        if (err_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: udp_receive_port_filter_core.f
+incdir+rtl
rtl/udprf_pkg.sv
rtl/udprf_cell.sv
rtl/udp_receive_port_filter_core.sv
verif/tb_udp_receive_port_filter_core.sv
